FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BEZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BEZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BEZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define BEZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/bez_pkg.sv
// Package: commands, microcode word and microcode ROM of the Bezier point evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bez_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [1:0] {
		STEP_IDLE = 2'd0,
		STEP_MB   = 2'd1,
		STEP_MC   = 2'd2,
		STEP_MD   = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		ACC_HOLD   = 2'd0,
		ACC_LOAD_A = 2'd1,
		ACC_MAC    = 2'd2
	} acc_op_t;

	typedef enum logic [1:0] {
		COEF_B = 2'd0,
		COEF_C = 2'd1,
		COEF_D = 2'd2
	} coef_t;

	typedef enum logic [1:0] {
		JC_NONE          = 2'd0,
		JC_STAY_NO_EVAL  = 2'd1,
		JC_STAY_OUT_BUSY = 2'd2
	} jc_t;

	typedef struct packed {
		logic    in_rdy;
		acc_op_t acc_op;
		coef_t   coef;
		logic    out_we;
		jc_t     jc;
		step_t   next_step;
	} ucode_t;

	typedef struct packed {
		acc_op_t acc_op;
		coef_t   coef;
		logic    out_ld;
	} axis_ctl_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t u;
		u = '{in_rdy: 1'b0, acc_op: ACC_HOLD, coef: COEF_B, out_we: 1'b0,
			jc: JC_NONE, next_step: STEP_IDLE};
		unique case (s)
			STEP_IDLE: u = '{in_rdy: 1'b1, acc_op: ACC_LOAD_A, coef: COEF_B,
				out_we: 1'b0, jc: JC_STAY_NO_EVAL, next_step: STEP_MB};
			STEP_MB: u = '{in_rdy: 1'b0, acc_op: ACC_MAC, coef: COEF_B,
				out_we: 1'b0, jc: JC_NONE, next_step: STEP_MC};
			STEP_MC: u = '{in_rdy: 1'b0, acc_op: ACC_MAC, coef: COEF_C,
				out_we: 1'b0, jc: JC_NONE, next_step: STEP_MD};
			STEP_MD: u = '{in_rdy: 1'b0, acc_op: ACC_HOLD, coef: COEF_D,
				out_we: 1'b1, jc: JC_STAY_OUT_BUSY, next_step: STEP_IDLE};
			default: u = '{in_rdy: 1'b0, acc_op: ACC_HOLD, coef: COEF_B,
				out_we: 1'b0, jc: JC_NONE, next_step: STEP_IDLE};
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bez_axis.sv
// One axis datapath: Bezier coefficients, Horner multiply-accumulate and clamped output.
`timescale 1ns / 1ps
`default_nettype none

module bez_axis #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire  [COORD_BITS-1:0]      p [4],
	input  wire  [T_FRAC_BITS:0]       t,
	input  wire  bez_pkg::axis_ctl_t   ctl,
	output logic [COORD_BITS-1:0]      point
);

	localparam int CW     = COORD_BITS;
	localparam int F      = T_FRAC_BITS;
	localparam int TW     = F + 1;
	localparam int COEF_W = CW + 4;
	localparam int ACC_W  = CW + F + 5;
	localparam int PT_W   = ACC_W - F;

	logic signed [COEF_W-1:0]  e0, e1, e2, e3;
	logic signed [COEF_W-1:0]  coef_a, coef_b, coef_c, coef_d, coef_sel;
	logic signed [COEF_W-1:0]  s02, d12, d10, six1;
	logic signed [ACC_W-1:0]   a_sh, sel_sh, mac;
	logic signed [ACC_W+TW:0]  prod, prod_sh;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PT_W-1:0]    pt;
	logic [CW-1:0]             pt_clamp;
	logic [CW-1:0]             point_q;

	assign e0 = $signed({4'b0000, p[0]});
	assign e1 = $signed({4'b0000, p[1]});
	assign e2 = $signed({4'b0000, p[2]});
	assign e3 = $signed({4'b0000, p[3]});

	// a = -P0 + 3P1 - 3P2 + P3, b = 3P0 - 6P1 + 3P2, c = 3P1 - 3P0, d = P0
	assign d12    = e1 - e2;
	assign s02    = e0 + e2;
	assign d10    = e1 - e0;
	assign six1   = e1 + e1 + e1 + e1 + e1 + e1;
	assign coef_a = e3 - e0 + d12 + d12 + d12;
	assign coef_b = s02 + s02 + s02 - six1;
	assign coef_c = d10 + d10 + d10;
	assign coef_d = e0;

	always_comb begin
		case (ctl.coef)
			bez_pkg::COEF_B: coef_sel = coef_b;
			bez_pkg::COEF_C: coef_sel = coef_c;
			bez_pkg::COEF_D: coef_sel = coef_d;
			default:         coef_sel = coef_b;
		endcase
	end

	assign a_sh   = $signed({coef_a[COEF_W-1], coef_a, {F{1'b0}}});
	assign sel_sh = $signed({coef_sel[COEF_W-1], coef_sel, {F{1'b0}}});

	// floor(acc * t / 2^F) by arithmetic shift
	assign prod    = acc_q * $signed({1'b0, t});
	assign prod_sh = prod >>> F;
	assign mac     = $signed(prod_sh[ACC_W-1:0]) + sel_sh;

	assign pt = $signed(mac[ACC_W-1:F]);

	always_comb begin
		if (pt[PT_W-1]) begin
			pt_clamp = '0;
		end else if (|pt[PT_W-2:CW]) begin
			pt_clamp = '1;
		end else begin
			pt_clamp = pt[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.acc_op)
			bez_pkg::ACC_LOAD_A: acc_q <= a_sh;
			bez_pkg::ACC_MAC:    acc_q <= mac;
			default:             acc_q <= acc_q;
		endcase
		if (ctl.out_ld) begin
			point_q <= pt_clamp;
		end
	end

	assign point = point_q;

endmodule

`default_nettype wire

FILE: rtl/cubic_bezier_point_eval.sv
// Top level: cubic Bezier point evaluator with microcoded Horner sequencer.
//
// Input channel (in_valid/in_ready): command selects a load or an evaluate beat.
// A load beat writes control point point_index from coord_x/coord_y and gives
// no result. An evaluate beat brings t_param (values above 1.0 saturate to
// 1.0) and gives one result beat on curve_x/curve_y.
// Each axis owns one multiplier; a four-step microcode program runs the three
// dependent Horner multiply-accumulates through it. in_ready stays low while
// the program runs (steps MB, MC, MD); the result is registered on step MD.
// Output channel (out_valid/out_ready): the result sits in an output register,
// so the next beat is accepted while a result waits. If the receiver still
// stalls when the following result is due, the sequencer holds on its last
// step and in_ready stays low until the register drains.
// Reset clears the sequencer and out_valid; control points are undefined until
// loaded and must be loaded before any evaluate beat uses them.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cubic_bezier_point_eval #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    command,
	input  wire  [1:0]             point_index,
	input  wire  [COORD_BITS-1:0]  coord_x,
	input  wire  [COORD_BITS-1:0]  coord_y,
	input  wire  [T_FRAC_BITS:0]   t_param,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [COORD_BITS-1:0]  curve_x,
	output logic [COORD_BITS-1:0]  curve_y
);

	localparam int CW = COORD_BITS;
	localparam int F  = T_FRAC_BITS;

	bez_pkg::step_t     step_q, step_d;
	bez_pkg::ucode_t    uc;
	bez_pkg::axis_ctl_t axis_ctl;

	logic [CW-1:0] ctrl_x_q [4];
	logic [CW-1:0] ctrl_y_q [4];
	logic [F:0]    t_sat;
	logic [F:0]    t_q;
	logic          in_fire, eval_fire, load_fire;
	logic          out_valid_q, out_busy, out_ld;

	assign uc       = bez_pkg::ucode_rom(step_q);
	assign in_ready = uc.in_rdy;

	assign in_fire   = in_valid & in_ready;
	assign eval_fire = in_fire & (command == bez_pkg::CMD_EVAL);
	assign load_fire = in_fire & (command == bez_pkg::CMD_LOAD);

	assign out_busy = out_valid_q & ~out_ready;
	assign out_ld   = uc.out_we & ~out_busy;

	// next step
	always_comb begin
		unique case (uc.jc)
			bez_pkg::JC_NONE:          step_d = uc.next_step;
			bez_pkg::JC_STAY_NO_EVAL:  step_d = eval_fire ? uc.next_step : step_q;
			bez_pkg::JC_STAY_OUT_BUSY: step_d = out_busy ? step_q : uc.next_step;
			default:                   step_d = bez_pkg::STEP_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		axis_ctl.acc_op = uc.acc_op;
		axis_ctl.coef   = uc.coef;
		axis_ctl.out_ld = out_ld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= bez_pkg::STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// t above 1.0 saturates to 1.0
	assign t_sat = (t_param[F] && |t_param[F-1:0]) ? {1'b1, {F{1'b0}}} : t_param;

	always_ff @(posedge clk) begin
		if (load_fire) begin
			ctrl_x_q[point_index] <= coord_x;
			ctrl_y_q[point_index] <= coord_y;
		end
		if (eval_fire) begin
			t_q <= t_sat;
		end
	end

	bez_axis #(
		.COORD_BITS  (COORD_BITS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_axis_x (
		.clk   (clk),
		.p     (ctrl_x_q),
		.t     (t_q),
		.ctl   (axis_ctl),
		.point (curve_x)
	);

	bez_axis #(
		.COORD_BITS  (COORD_BITS),
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_axis_y (
		.clk   (clk),
		.p     (ctrl_y_q),
		.t     (t_q),
		.ctl   (axis_ctl),
		.point (curve_y)
	);

	assign out_valid = out_valid_q;

	`BEZ_ASSERT_NEXT(a_eval_starts, clk, arst_n, eval_fire, step_q == bez_pkg::STEP_MB, "evaluate beat did not start the program")
	`BEZ_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, out_ld, !(out_valid_q && !out_ready), "result overwritten before taken")
	`BEZ_ASSERT_IMPLY(a_busy_no_accept, clk, arst_n, step_q != bez_pkg::STEP_IDLE, !in_ready, "input accepted while program runs")

endmodule

`default_nettype wire
